// ===== src/flight_safety_limit_monitor_macros.svh =====
// ----------------------------------------------------------------------------
// flight_safety_limit_monitor_macros
// Assertion macros for the checker file of the limit monitor.
// ----------------------------------------------------------------------------
`ifndef FLIGHT_SAFETY_LIMIT_MONITOR_MACROS_SVH
`define FLIGHT_SAFETY_LIMIT_MONITOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define FSLM_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset
`define FSLM_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fslm_pkg.sv =====
// ----------------------------------------------------------------------------
// fslm_pkg
// Types, register indexes and reset values of the flight safety limit monitor.
// ----------------------------------------------------------------------------
package fslm_pkg;

    localparam int NUM_LANES = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIMIT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALTITUDE_CEILING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALTITUDE_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_MAX         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMBALANCE_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_COUNT_LIMIT = 3'd5;

    localparam logic [14:0]        RST_ANGLE_LIMIT       = 15'd6434;
    localparam logic signed [15:0] RST_ALTITUDE_CEILING  = 16'sd2400;
    localparam logic signed [15:0] RST_ALTITUDE_FLOOR    = -16'sd80;
    localparam logic [14:0]        RST_MOTOR_MAX         = 15'd25600;
    localparam logic [15:0]        RST_IMBALANCE_LIMIT   = 16'd10240;
    localparam logic [3:0]         RST_FAULT_COUNT_LIMIT = 4'd5;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] altitude;
        logic signed [15:0] front_left_cmd;
        logic signed [15:0] front_right_cmd;
        logic signed [15:0] rear_left_cmd;
        logic signed [15:0] rear_right_cmd;
        logic               stop_request;
    } t_in_word;

    typedef struct packed {
        logic [14:0] front_left_out;
        logic [14:0] front_right_out;
        logic [14:0] rear_left_out;
        logic [14:0] rear_right_out;
        logic        emergency_flag;
        logic [3:0]  fault_level;
    } t_out_word;

    typedef struct packed {
        logic               over_max;
        logic [14:0]        clamped;
        logic signed [15:0] cmd;
    } t_lane_res;

    typedef struct packed {
        t_lane_res [NUM_LANES-1:0] lane;
        logic                      limit_fault;
        logic                      stop_request;
    } t_stage1;

endpackage

// ===== src/fslm_motor_lane.sv =====
// ----------------------------------------------------------------------------
// fslm_motor_lane
// One motor lane: checks the command against the maximum and clamps it.
// ----------------------------------------------------------------------------
module fslm_motor_lane (
    input  logic signed [15:0]   i_cmd,
    input  logic [14:0]          i_motor_max,
    output fslm_pkg::t_lane_res  o_res
);
    import fslm_pkg::*;

    logic signed [15:0] max_s;
    logic               over;

    assign max_s = signed'({1'b0, i_motor_max});
    assign over  = i_cmd > max_s;

    always_comb begin
        o_res.over_max = over;
        o_res.cmd      = i_cmd;
        if (i_cmd < 16'sd0) begin
            o_res.clamped = '0;
        end else if (over) begin
            o_res.clamped = i_motor_max;
        end else begin
            o_res.clamped = i_cmd[14:0];
        end
    end

endmodule

// ===== src/fslm_limit_check.sv =====
// ----------------------------------------------------------------------------
// fslm_limit_check
// Attitude and altitude envelope check of one sample.
// ----------------------------------------------------------------------------
module fslm_limit_check (
    input  logic signed [15:0] i_roll,
    input  logic signed [15:0] i_pitch,
    input  logic signed [15:0] i_altitude,
    input  logic [14:0]        i_angle_limit,
    input  logic signed [15:0] i_ceiling,
    input  logic signed [15:0] i_floor,
    output logic               o_fault
);
    import fslm_pkg::*;

    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [16:0] roll_x;
    logic signed [16:0] pitch_x;
    logic               angle_fault;
    logic               alt_fault;

    assign lim_pos = signed'({2'b00, i_angle_limit});
    assign lim_neg = -lim_pos;
    assign roll_x  = 17'(i_roll);
    assign pitch_x = 17'(i_pitch);

    assign angle_fault = (roll_x > lim_pos) || (roll_x < lim_neg)
                      || (pitch_x > lim_pos) || (pitch_x < lim_neg);
    assign alt_fault   = (i_altitude > i_ceiling) || (i_altitude < i_floor);
    assign o_fault     = angle_fault || alt_fault;

endmodule

// ===== src/fslm_merge.sv =====
// ----------------------------------------------------------------------------
// fslm_merge
// Merge stage: spread check, fault counter, stop decision, output register.
// ----------------------------------------------------------------------------
module fslm_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  fslm_pkg::t_stage1   i_stage,
    input  logic [15:0]         i_imbalance_limit,
    input  logic [3:0]          i_fault_count_limit,
    output logic                o_valid,
    input  logic                i_ready,
    output fslm_pkg::t_out_word o_data
);
    import fslm_pkg::*;

    logic               r_valid;
    logic [3:0]         r_count;
    logic [3:0]         n_count;
    t_out_word          r_data;
    t_out_word          n_data;
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    logic [16:0]        spread;
    logic               any_over;
    logic               fault;
    logic               forced;
    logic               advance;

    assign o_ready = !r_valid || i_ready;
    assign advance = i_valid && o_ready;

    always_comb begin
        hi       = i_stage.lane[0].cmd;
        lo       = i_stage.lane[0].cmd;
        any_over = 1'b0;
        for (int k = 0; k < NUM_LANES; k++) begin
            if (i_stage.lane[k].cmd > hi) hi = i_stage.lane[k].cmd;
            if (i_stage.lane[k].cmd < lo) lo = i_stage.lane[k].cmd;
            any_over = any_over || i_stage.lane[k].over_max;
        end
    end

    assign spread = 17'(17'(hi) - 17'(lo));
    assign fault  = any_over || i_stage.limit_fault || i_stage.stop_request
                 || (spread > {1'b0, i_imbalance_limit});

    always_comb begin
        n_count = r_count;
        if (fault) begin
            if (r_count < i_fault_count_limit) n_count = r_count + 4'd1;
        end else if (r_count != 4'd0) begin
            n_count = r_count - 4'd1;
        end
    end

    assign forced = (n_count >= i_fault_count_limit) || i_stage.stop_request;

    always_comb begin
        n_data.front_left_out  = forced ? '0 : i_stage.lane[0].clamped;
        n_data.front_right_out = forced ? '0 : i_stage.lane[1].clamped;
        n_data.rear_left_out   = forced ? '0 : i_stage.lane[2].clamped;
        n_data.rear_right_out  = forced ? '0 : i_stage.lane[3].clamped;
        n_data.emergency_flag  = forced;
        n_data.fault_level     = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/flight_safety_limit_monitor.sv =====
// ----------------------------------------------------------------------------
// flight_safety_limit_monitor
// Stages: two register stages (lane stage, merge); a word accepted at the
// input is registered in the lane stage, then in the merge output register.
// Throughput: one word per cycle while the output is not stalled; the fault
// counter update in the merge stage is the loop that sets it.
// Reset: synchronous active low; limits return to defaults, counter clears,
// pipeline empties.
// ----------------------------------------------------------------------------
module flight_safety_limit_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [fslm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fslm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  fslm_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output fslm_pkg::t_out_word                 o_out_data
);
    import fslm_pkg::*;

    logic [14:0]        r_angle_limit;
    logic signed [15:0] r_ceiling;
    logic signed [15:0] r_floor;
    logic [14:0]        r_motor_max;
    logic [15:0]        r_imbalance;
    logic [3:0]         r_count_limit;

    logic               r_s1_valid;
    t_stage1            r_s1;
    t_stage1            n_s1;
    logic               merge_ready;
    logic               s1_ready;
    logic               limit_fault;
    t_lane_res [NUM_LANES-1:0] lane_res;
    logic signed [15:0] lane_cmd [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_limit <= RST_ANGLE_LIMIT;
            r_ceiling     <= RST_ALTITUDE_CEILING;
            r_floor       <= RST_ALTITUDE_FLOOR;
            r_motor_max   <= RST_MOTOR_MAX;
            r_imbalance   <= RST_IMBALANCE_LIMIT;
            r_count_limit <= RST_FAULT_COUNT_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ANGLE_LIMIT:       r_angle_limit <= i_cfg_data[14:0];
                CFG_ALTITUDE_CEILING:  r_ceiling     <= signed'(i_cfg_data);
                CFG_ALTITUDE_FLOOR:    r_floor       <= signed'(i_cfg_data);
                CFG_MOTOR_MAX:         r_motor_max   <= i_cfg_data[14:0];
                CFG_IMBALANCE_LIMIT:   r_imbalance   <= i_cfg_data;
                CFG_FAULT_COUNT_LIMIT: r_count_limit <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign lane_cmd[0] = i_in_data.front_left_cmd;
    assign lane_cmd[1] = i_in_data.front_right_cmd;
    assign lane_cmd[2] = i_in_data.rear_left_cmd;
    assign lane_cmd[3] = i_in_data.rear_right_cmd;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        fslm_motor_lane u_lane (
            .i_cmd       (lane_cmd[g]),
            .i_motor_max (r_motor_max),
            .o_res       (lane_res[g])
        );
    end

    fslm_limit_check u_limit (
        .i_roll        (i_in_data.roll_angle),
        .i_pitch       (i_in_data.pitch_angle),
        .i_altitude    (i_in_data.altitude),
        .i_angle_limit (r_angle_limit),
        .i_ceiling     (r_ceiling),
        .i_floor       (r_floor),
        .o_fault       (limit_fault)
    );

    always_comb begin
        n_s1.lane         = lane_res;
        n_s1.limit_fault  = limit_fault;
        n_s1.stop_request = i_in_data.stop_request;
    end

    assign s1_ready   = !r_s1_valid || merge_ready;
    assign o_in_ready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1 <= n_s1;
        end
    end

    fslm_merge u_merge (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (r_s1_valid),
        .o_ready             (merge_ready),
        .i_stage             (r_s1),
        .i_imbalance_limit   (r_imbalance),
        .i_fault_count_limit (r_count_limit),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_data              (o_out_data)
    );

endmodule

// ===== src/fslm_checker.sv =====
// ----------------------------------------------------------------------------
// fslm_checker
// Port-level checks of the flight safety limit monitor, bound to the top.
// ----------------------------------------------------------------------------
`include "flight_safety_limit_monitor_macros.svh"

module fslm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input fslm_pkg::t_out_word o_out_data
);
    import fslm_pkg::*;

    logic [3:0] r_last_level;
    logic       out_take;
    logic       step_ok;
    logic       motors_zero;

    assign out_take = o_out_valid && i_out_ready;
    assign step_ok  = (o_out_data.fault_level == r_last_level)
                   || (o_out_data.fault_level == r_last_level + 4'd1)
                   || (o_out_data.fault_level + 4'd1 == r_last_level);
    assign motors_zero = (o_out_data.front_left_out == '0)
                      && (o_out_data.front_right_out == '0)
                      && (o_out_data.rear_left_out == '0)
                      && (o_out_data.rear_right_out == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= '0;
        end else if (out_take) begin
            r_last_level <= o_out_data.fault_level;
        end
    end

    `FSLM_ASSERT_RST(a_reset_empty, !i_rst_n, !o_out_valid, "output valid after reset")
    `FSLM_ASSERT(a_stop_zero, o_out_valid && o_out_data.emergency_flag, motors_zero, "motors not zero on emergency")
    `FSLM_ASSERT(a_level_step, out_take, step_ok, "fault level moved by more than one")
    `FSLM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled output word changed")

endmodule

bind flight_safety_limit_monitor fslm_checker u_fslm_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the flight safety limit monitor. Directed samples on the reset limits
// come first, then random samples over several limit settings, among them the
// extremes, a zero count limit and a counter left above a lowered limit. Each
// output word is compared field by field against its typed table row or else
// a local model of the limits, saturating fault counter, stop and clamp logic.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fslm_pkg::*;

    localparam int IN_W = $bits(t_in_word);
    localparam int NUM_PHASES = 12;
    localparam int PHASE_WORDS = 165;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_LIMIT = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {
        SPOIL_ROLL, SPOIL_PITCH, SPOIL_HIGH, SPOIL_LOW, SPOIL_MOTOR, SPOIL_SPREAD, SPOIL_STOP
    } t_spoil;

    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] ceiling;
        logic [15:0] floor;
        logic [15:0] motor;
        logic [15:0] spread;
        logic [15:0] count;
    } t_limits;

    typedef struct {
        int roll;
        int pitch;
        int alt;
        int fl;
        int fr;
        int rl;
        int rr;
        bit stop;
        bit typed;
        int ofl;
        int ofr;
        int orl;
        int orr;
        bit flag;
        int level;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_data;

    logic [14:0]        ang_lim;
    logic signed [15:0] alt_ceil;
    logic signed [15:0] alt_floor;
    logic [14:0]        mot_max;
    logic [15:0]        imb_lim;
    logic [3:0]         cnt_lim;
    logic [3:0]         fault_cnt;

    t_out_word clamped_words[$];
    t_out_word due;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 22;
    int        recv_idle_pct = 65;

    t_row limit_cases [24] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
        '{6434, -6434, 2400, 25600, 25600, 25600, 25600, 0, 1,
          25600, 25600, 25600, 25600, 0, 0},
        '{-6434, 6434, -80, 15360, 15360, 15360, 5120, 0, 1,
          15360, 15360, 15360, 5120, 0, 0},
        '{6435, 0, 0, 100, 100, 100, 100, 0, 1, 100, 100, 100, 100, 0, 1},
        '{0, -6435, 0, 100, 100, 100, 100, 0, 1, 100, 100, 100, 100, 0, 2},
        '{0, 0, 2401, 100, 100, 100, 100, 0, 1, 100, 100, 100, 100, 0, 3},
        '{0, 0, -81, 100, 100, 100, 100, 0, 1, 100, 100, 100, 100, 0, 4},
        '{0, 0, 0, 25601, 25600, 25600, 25600, 0, 1, 0, 0, 0, 0, 1, 5},
        '{0, 0, 0, 0, 0, 0, 10241, 0, 1, 0, 0, 0, 0, 1, 5},
        '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 4},
        '{0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 1, 5},
        '{0, 0, 0, 1000, 1000, 1000, 1000, 0, 1, 1000, 1000, 1000, 1000, 0, 4},
        '{0, 0, 0, -100, -100, -100, -100, 0, 1, 0, 0, 0, 0, 0, 3},
        '{-32768, 32767, 32767, 32767, -32768, 32767, -32768, 1, 1, 0, 0, 0, 0, 1, 4},
        '{32767, -32768, -32768, -32768, -32768, -32768, -32768, 0, 1, 0, 0, 0, 0, 1, 5},
        '{0, 0, 0, 25600, 25600, 25600, 15360, 0, 1, 25600, 25600, 25600, 15360, 0, 4},
        '{12345, -3, 1000, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{21845, -21846, 21845, 21845, -21846, 21845, -21846, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-21846, 21845, -21846, -21846, 21845, -21846, 21845, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0}
    };

    t_limits corner_limits [3] = '{
        '{16'h9922, 16'h0960, 16'hFFB0, 16'hE400, 16'h2800, 16'hFFF1},
        '{16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h000F}
    };

    flight_safety_limit_monitor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_out_word limit_sample(input t_in_word w);
        int          lim, top, roll, pitch, alt, hi, lo, v;
        int          cmd[4];
        logic [14:0] lane_out[4];
        logic        fault, forced;
        lim = int'(ang_lim);
        top = int'(mot_max);
        roll = int'($signed(w.roll_angle));
        pitch = int'($signed(w.pitch_angle));
        alt = int'($signed(w.altitude));
        cmd[0] = int'($signed(w.front_left_cmd));
        cmd[1] = int'($signed(w.front_right_cmd));
        cmd[2] = int'($signed(w.rear_left_cmd));
        cmd[3] = int'($signed(w.rear_right_cmd));
        fault = w.stop_request;
        if (roll > lim || roll < -lim || pitch > lim || pitch < -lim) fault = 1'b1;
        if (alt > int'(alt_ceil) || alt < int'(alt_floor)) fault = 1'b1;
        hi = cmd[0];
        lo = cmd[0];
        for (int i = 0; i < 4; i++) begin
            if (cmd[i] > top) fault = 1'b1;
            if (cmd[i] > hi) hi = cmd[i];
            if (cmd[i] < lo) lo = cmd[i];
        end
        if (hi - lo > int'(imb_lim)) fault = 1'b1;
        if (fault) begin
            if (fault_cnt < cnt_lim) fault_cnt = fault_cnt + 4'd1;
        end else if (fault_cnt != 4'd0) begin
            fault_cnt = fault_cnt - 4'd1;
        end
        forced = (fault_cnt >= cnt_lim) || w.stop_request;
        for (int i = 0; i < 4; i++) begin
            v = forced ? 0 : cmd[i];
            if (v > top) v = top;
            if (v < 0) v = 0;
            lane_out[i] = 15'(v);
        end
        return '{lane_out[0], lane_out[1], lane_out[2], lane_out[3], forced, fault_cnt};
    endfunction

    function automatic t_in_word pick_sample(input int bias);
        t_in_word w;
        int       lim, top, base, span, lane;
        int       cmd[4];
        w = IN_W'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(99) < 15) return w;
        lim = int'(ang_lim);
        top = int'(mot_max);
        lane = $urandom_range(3);
        w.roll_angle = 16'(int'($urandom_range(2 * lim)) - lim);
        w.pitch_angle = 16'(int'($urandom_range(2 * lim)) - lim);
        if (alt_floor <= alt_ceil) begin
            w.altitude = 16'(int'(alt_floor)
                + int'($urandom_range(int'(alt_ceil) - int'(alt_floor))));
        end
        base = $urandom_range(top);
        span = (int'(imb_lim) < top - base) ? int'(imb_lim) : top - base;
        for (int i = 0; i < 4; i++) cmd[i] = base + int'($urandom_range(span));
        w.stop_request = 1'b0;
        if ($urandom_range(99) < bias) begin
            case (t_spoil'($urandom_range(SPOIL_STOP)))
                SPOIL_ROLL: w.roll_angle = 16'($urandom_range(1) ? lim + 1 : -lim - 1);
                SPOIL_PITCH: w.pitch_angle = 16'($urandom_range(1) ? lim + 1 : -lim - 1);
                SPOIL_HIGH: w.altitude = 16'(int'(alt_ceil) + 1);
                SPOIL_LOW: w.altitude = 16'(int'(alt_floor) - 1);
                SPOIL_MOTOR: cmd[lane] = top + 1;
                SPOIL_SPREAD: cmd[lane] = base - int'(imb_lim) - 1;
                default: w.stop_request = 1'b1;
            endcase
        end else if ($urandom_range(3) == 0) begin
            w.roll_angle = 16'(lim);
            w.pitch_angle = 16'(-lim);
            w.altitude = $urandom_range(1) ? alt_ceil : alt_floor;
            cmd[lane] = top;
        end
        w.front_left_cmd = 16'(cmd[0]);
        w.front_right_cmd = 16'(cmd[1]);
        w.rear_left_cmd = 16'(cmd[2]);
        w.rear_right_cmd = 16'(cmd[3]);
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ANGLE_LIMIT: ang_lim = data[14:0];
            CFG_ALTITUDE_CEILING: alt_ceil = data;
            CFG_ALTITUDE_FLOOR: alt_floor = data;
            CFG_MOTOR_MAX: mot_max = data[14:0];
            CFG_IMBALANCE_LIMIT: imb_lim = data;
            CFG_FAULT_COUNT_LIMIT: cnt_lim = data[3:0];
            default: ;
        endcase
    endtask

    task automatic load_limits(input t_limits s);
        put_reg(CFG_SPARE_HI, 16'($urandom));
        put_reg(CFG_ANGLE_LIMIT, s.angle);
        put_reg(CFG_ALTITUDE_CEILING, s.ceiling);
        put_reg(CFG_ALTITUDE_FLOOR, s.floor);
        put_reg(CFG_MOTOR_MAX, s.motor);
        put_reg(CFG_IMBALANCE_LIMIT, s.spread);
        put_reg(CFG_FAULT_COUNT_LIMIT, s.count);
        put_reg(CFG_SPARE_LO, 16'($urandom));
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic drive_sample(input t_in_word w, input bit typed, input t_out_word typed_res);
        t_out_word res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = limit_sample(w);
        clamped_words.push_back(typed ? typed_res : res);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (clamped_words.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (clamped_words.size() == 0) begin
                flag_mismatch("word with nothing pending, fault_level",
                              int'(o_out_data.fault_level), -1);
            end else begin
                due = clamped_words.pop_front();
                if (o_out_data.front_left_out !== due.front_left_out)
                    flag_mismatch("front_left_out", int'(o_out_data.front_left_out),
                                  int'(due.front_left_out));
                if (o_out_data.front_right_out !== due.front_right_out)
                    flag_mismatch("front_right_out", int'(o_out_data.front_right_out),
                                  int'(due.front_right_out));
                if (o_out_data.rear_left_out !== due.rear_left_out)
                    flag_mismatch("rear_left_out", int'(o_out_data.rear_left_out),
                                  int'(due.rear_left_out));
                if (o_out_data.rear_right_out !== due.rear_right_out)
                    flag_mismatch("rear_right_out", int'(o_out_data.rear_right_out),
                                  int'(due.rear_right_out));
                if (o_out_data.emergency_flag !== due.emergency_flag)
                    flag_mismatch("emergency_flag", int'(o_out_data.emergency_flag),
                                  int'(due.emergency_flag));
                if (o_out_data.fault_level !== due.fault_level)
                    flag_mismatch("fault_level", int'(o_out_data.fault_level),
                                  int'(due.fault_level));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_row      c;
        t_in_word  w;
        t_out_word r;
        t_limits   lim;
        int        alt_a, alt_b, bias;
        ang_lim = RST_ANGLE_LIMIT;
        alt_ceil = RST_ALTITUDE_CEILING;
        alt_floor = RST_ALTITUDE_FLOOR;
        mot_max = RST_MOTOR_MAX;
        imb_lim = RST_IMBALANCE_LIMIT;
        cnt_lim = RST_FAULT_COUNT_LIMIT;
        fault_cnt = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (limit_cases[k]) begin
            c = limit_cases[k];
            w = '{16'(c.roll), 16'(c.pitch), 16'(c.alt), 16'(c.fl), 16'(c.fr),
                  16'(c.rl), 16'(c.rr), c.stop};
            r = '{15'(c.ofl), 15'(c.ofr), 15'(c.orl), 15'(c.orr), c.flag, 4'(c.level)};
            drive_sample(w, c.typed, r);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p < NUM_PHASES / 3) begin
                send_idle_pct = 22;
                recv_idle_pct = 65;
            end else if (p < 2 * NUM_PHASES / 3) begin
                send_idle_pct = 65;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p < 3) begin
                lim = corner_limits[p];
            end else begin
                alt_a = int'($urandom_range(65535)) - 32768;
                alt_b = int'($urandom_range(65535)) - 32768;
                if (alt_a > alt_b && $urandom_range(9) != 0) begin
                    lim.floor = 16'(alt_b);
                    lim.ceiling = 16'(alt_a);
                end else begin
                    lim.floor = 16'(alt_a);
                    lim.ceiling = 16'(alt_b);
                end
                lim.angle = ($urandom_range(7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(25736));
                lim.motor = ($urandom_range(7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(32767));
                lim.spread = ($urandom_range(2) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(int'(lim.motor[14:0])));
                lim.count = 16'($urandom_range(15));
            end
            load_limits(lim);
            bias = $urandom_range(10, 90);
            repeat (PHASE_WORDS) drive_sample(pick_sample(bias), 1'b0, '0);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== flight_safety_limit_monitor.f =====
+incdir+src
src/fslm_pkg.sv
src/fslm_motor_lane.sv
src/fslm_limit_check.sv
src/fslm_merge.sv
src/flight_safety_limit_monitor.sv
src/fslm_checker.sv
tb/sv/tb.sv
